@@ src/sah_binned_split_finder_assert.svh @@
// Assertion macros for the binned split finder.
`ifndef SAH_BINNED_SPLIT_FINDER_ASSERT_SVH
`define SAH_BINNED_SPLIT_FINDER_ASSERT_SVH

// same-cycle implication
`define SBSF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("sbsf assertion failed");

// next-cycle implication
`define SBSF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("sbsf assertion failed");

`endif

@@ src/sbsf_pkg.sv @@
// Package: types, constants and controller states for the binned split finder.
package sbsf_pkg;

	localparam int BUCKETS_DEF   = 12;
	localparam int MAX_PRIMS_DEF = 4096;
	localparam int COORD_DEF     = 24;
	localparam int SMALL_SET_DEF = 4;

	localparam int COORD_W  = 24;
	localparam int AXIS_W   = 2;
	localparam int BUCKET_W = 4;
	localparam int LEFT_W   = 13;
	localparam int COST_W   = 64;
	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;
	localparam logic [AXIS_W-1:0] AXIS_BAD = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] box_min_x;
		logic [COORD_W-1:0] box_min_y;
		logic [COORD_W-1:0] box_min_z;
		logic [COORD_W-1:0] box_max_x;
		logic [COORD_W-1:0] box_max_y;
		logic [COORD_W-1:0] box_max_z;
		logic [COORD_W-1:0] centroid_low;
		logic [COORD_W-1:0] centroid_high;
		logic [AXIS_W-1:0]  axis_sel;
		logic               last_item;
	} in_t;

	typedef struct packed {
		logic                split_mode;
		logic [BUCKET_W-1:0] split_bucket;
		logic [LEFT_W-1:0]   left_count;
		logic                degenerate;
	} out_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_RD,
		S_WR,
		S_LAST,
		S_SW_INIT,
		S_R_RD,
		S_R_MRG,
		S_R_COST,
		S_R_WR,
		S_L_INIT,
		S_L_RD,
		S_L_MRG,
		S_L_COST,
		S_L_CMP,
		S_RESULT
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic set_ovf;
		logic div_step;
		logic bkt_rd;
		logic bkt_wr;
		logic r_init;
		logic l_init;
		logic sw_rd;
		logic mrg;
		logic cost_step;
		logic cost_wr;
		logic p_dec;
		logic p_inc;
		logic cmp;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic ovf_now;
		logic div_last;
		logic is_last;
		logic need_sweep;
		logic cost_last;
		logic p_low_end;
		logic p_high_end;
		logic out_free;
	} sts_t;

endpackage

@@ src/sbsf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sbsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ src/sbsf_ctrl.sv @@
// Controller state machine: sequences binning per request and the partition sweep.
module sbsf_ctrl import sbsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (item_valid) state_d = S_PREP;
			S_PREP:    state_d = sts.ovf_now ? S_LAST : S_DIV;
			S_DIV:     if (sts.div_last) state_d = S_RD;
			S_RD:      state_d = S_WR;
			S_WR:      state_d = S_LAST;
			S_LAST: begin
				if (!sts.is_last) state_d = S_IDLE;
				else if (sts.need_sweep) state_d = S_SW_INIT;
				else state_d = S_RESULT;
			end
			S_SW_INIT: state_d = S_R_RD;
			S_R_RD:    state_d = S_R_MRG;
			S_R_MRG:   state_d = S_R_COST;
			S_R_COST:  if (sts.cost_last) state_d = S_R_WR;
			S_R_WR:    state_d = sts.p_low_end ? S_L_INIT : S_R_RD;
			S_L_INIT:  state_d = S_L_RD;
			S_L_RD:    state_d = S_L_MRG;
			S_L_MRG:   state_d = S_L_COST;
			S_L_COST:  if (sts.cost_last) state_d = S_L_CMP;
			S_L_CMP:   state_d = sts.p_high_end ? S_RESULT : S_L_RD;
			S_RESULT:  if (sts.out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		item_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE:    cmd.load = item_valid;
			S_PREP: begin
				cmd.prep = 1'b1;
				cmd.set_ovf = sts.ovf_now;
			end
			S_DIV:     cmd.div_step = 1'b1;
			S_RD:      cmd.bkt_rd = 1'b1;
			S_WR:      cmd.bkt_wr = 1'b1;
			S_SW_INIT: cmd.r_init = 1'b1;
			S_R_RD:    cmd.sw_rd = 1'b1;
			S_R_MRG:   cmd.mrg = 1'b1;
			S_R_COST:  cmd.cost_step = 1'b1;
			S_R_WR: begin
				cmd.cost_wr = 1'b1;
				cmd.p_dec = !sts.p_low_end;
			end
			S_L_INIT:  cmd.l_init = 1'b1;
			S_L_RD:    cmd.sw_rd = 1'b1;
			S_L_MRG:   cmd.mrg = 1'b1;
			S_L_COST:  cmd.cost_step = 1'b1;
			S_L_CMP: begin
				cmd.cmp = 1'b1;
				cmd.p_inc = !sts.p_high_end;
			end
			S_RESULT:  cmd.emit = sts.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

@@ src/sbsf_dpath.sv @@
// Datapath: bucket divider, bucket store, prefix/suffix merge, cost unit, result register.
module sbsf_dpath import sbsf_pkg::*; #(
	parameter int BUCKETS   = BUCKETS_DEF,
	parameter int MAX_PRIMS = MAX_PRIMS_DEF,
	parameter int COORD_BITS = COORD_DEF,
	parameter int SMALL_SET = SMALL_SET_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  in_t  item,
	output out_t result,
	output logic result_valid,
	input  logic result_stall,
	input  cmd_t cmd,
	output sts_t sts
);

	localparam int CB     = COORD_BITS;
	localparam int CNT_W  = $clog2(MAX_PRIMS + 1);
	localparam int QB     = $clog2(BUCKETS);
	localparam int DC_W   = $clog2(QB + 1);
	localparam int NUM_W  = CB + 3;
	localparam int R_W    = NUM_W + QB;
	localparam int ENT_W  = CNT_W + 6 * CB;
	localparam int HALF_W = CB + 1;
	localparam int AREA_W = 2 * HALF_W;
	localparam int MUL_W  = (CNT_W > HALF_W) ? CNT_W : HALF_W;
	localparam int PROD_W = 2 * MUL_W;
	localparam int FULL_W = CNT_W + AREA_W;
	localparam int SAT_W  = (FULL_W > COST_W) ? FULL_W : COST_W;

	in_t                     item_q;
	logic signed [CB-1:0]    clo_q, chi_q;
	logic [AXIS_W-1:0]       axis_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    ovf_q;
	logic [BUCKETS-1:0]      vld_q;

	logic [R_W-1:0]          r_q, dsh_q;
	logic [QB-1:0]           q_q;
	logic [DC_W-1:0]         dc_q;
	logic                    zero_q, top_q;
	logic [QB-1:0]           bkt;

	logic [QB-1:0]           p_q;
	logic [CNT_W-1:0]        acc_n_q;
	logic signed [CB-1:0]    acc_lo_q [3];
	logic signed [CB-1:0]    acc_hi_q [3];

	logic [2:0]              cs_q;
	logic [PROD_W-1:0]       prod_q, plo_q, mul_p;
	logic [MUL_W-1:0]        mul_a, mul_b;
	logic [AREA_W-1:0]       area_q;
	logic [COST_W-1:0]       cost_q, cost_fit, best_q, tot_s;
	logic [SAT_W-1:0]        cost_full;
	logic [COST_W:0]         tot;
	logic [QB-1:0]           best_bkt_q;
	logic [CNT_W-1:0]        best_left_q;
	logic [CB-1:0]           ext [3];

	logic signed [CB-1:0]    bmin [3];
	logic signed [CB-1:0]    bmax [3];
	logic signed [NUM_W-1:0] num, den;

	logic [ENT_W-1:0]        ent_rd, ent_wr;
	logic [COST_W-1:0]       cr_rd;
	logic                    degen, few_prims;
	out_t                    res_d;
	out_t                    result_q;
	logic                    result_valid_q;

	always_comb begin
		bmin[0] = item_q.box_min_x[CB-1:0];
		bmin[1] = item_q.box_min_y[CB-1:0];
		bmin[2] = item_q.box_min_z[CB-1:0];
		bmax[0] = item_q.box_max_x[CB-1:0];
		bmax[1] = item_q.box_max_y[CB-1:0];
		bmax[2] = item_q.box_max_z[CB-1:0];
	end

	// doubled centroid offset and doubled extent
	assign num = NUM_W'(bmin[axis_q]) + NUM_W'(bmax[axis_q]) - (NUM_W'(clo_q) <<< 1);
	assign den = (NUM_W'(chi_q) - NUM_W'(clo_q)) <<< 1;

	assign bkt = zero_q ? '0 : (top_q ? QB'(BUCKETS - 1) : q_q);

	// bucket store: {count, hi z..x, lo z..x}
	sbsf_ram #(.WIDTH(ENT_W), .DEPTH(BUCKETS)) u_bkt_ram (
		.clk     (clk),
		.wr_en   (cmd.bkt_wr),
		.wr_addr (bkt),
		.wr_data (ent_wr),
		.rd_en   (cmd.bkt_rd | cmd.sw_rd),
		.rd_addr (cmd.sw_rd ? p_q : bkt),
		.rd_data (ent_rd)
	);

	// suffix costs, written on the right-to-left pass
	sbsf_ram #(.WIDTH(COST_W), .DEPTH(BUCKETS)) u_cost_ram (
		.clk     (clk),
		.wr_en   (cmd.cost_wr),
		.wr_addr (p_q),
		.wr_data (cost_q),
		.rd_en   (cmd.sw_rd),
		.rd_addr (QB'(p_q + 1'b1)),
		.rd_data (cr_rd)
	);

	always_comb begin
		logic signed [CB-1:0] o_lo, o_hi;
		logic                 v;
		v = vld_q[bkt];
		ent_wr = '0;
		ent_wr[ENT_W-1 -: CNT_W] = v ? CNT_W'(ent_rd[ENT_W-1 -: CNT_W] + 1'b1) : CNT_W'(1);
		for (int a = 0; a < 3; a++) begin
			o_lo = ent_rd[a*CB +: CB];
			o_hi = ent_rd[(3+a)*CB +: CB];
			ent_wr[a*CB +: CB]     = (!v || bmin[a] < o_lo) ? bmin[a] : o_lo;
			ent_wr[(3+a)*CB +: CB] = (!v || bmax[a] > o_hi) ? bmax[a] : o_hi;
		end
	end

	always_comb begin
		logic signed [CB:0] d;
		for (int a = 0; a < 3; a++) begin
			d = (CB+1)'(acc_hi_q[a]) - (CB+1)'(acc_lo_q[a]);
			ext[a] = (acc_hi_q[a] > acc_lo_q[a]) ? CB'(d) : '0;
		end
	end

	always_comb begin
		unique case (cs_q)
			3'd0: begin mul_a = MUL_W'(ext[0]); mul_b = MUL_W'(ext[1]); end
			3'd1: begin mul_a = MUL_W'(ext[1]); mul_b = MUL_W'(ext[2]); end
			3'd2: begin mul_a = MUL_W'(ext[2]); mul_b = MUL_W'(ext[0]); end
			3'd4: begin mul_a = MUL_W'(acc_n_q); mul_b = MUL_W'(area_q[HALF_W-1:0]); end
			3'd5: begin mul_a = MUL_W'(acc_n_q); mul_b = MUL_W'(area_q[AREA_W-1:HALF_W]); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign cost_full = SAT_W'(plo_q) + (SAT_W'(prod_q) << HALF_W);
	assign cost_fit  = (cost_full > SAT_W'(COST_MAX)) ? COST_MAX : cost_full[COST_W-1:0];
	assign tot       = {1'b0, cost_q} + {1'b0, cr_rd};
	assign tot_s     = tot[COST_W] ? COST_MAX : tot[COST_W-1:0];

	assign degen     = (chi_q <= clo_q) || ovf_q;
	assign few_prims = (cnt_q <= CNT_W'(SMALL_SET));

	always_comb begin
		res_d = '0;
		priority if (degen) begin
			res_d.degenerate = 1'b1;
			res_d.left_count = LEFT_W'(cnt_q);
		end else if (few_prims) begin
			res_d.split_mode = 1'b1;
			res_d.left_count = LEFT_W'(cnt_q >> 1);
		end else begin
			res_d.split_bucket = BUCKET_W'(best_bkt_q);
			res_d.left_count   = LEFT_W'(best_left_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			vld_q <= '0;
			dc_q <= '0;
			cs_q <= '0;
			p_q <= '0;
			best_q <= COST_MAX;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.set_ovf) ovf_q <= 1'b1;
			if (cmd.bkt_wr) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
				vld_q[bkt] <= 1'b1;
			end
			if (cmd.prep) dc_q <= '0;
			else if (cmd.div_step) dc_q <= DC_W'(dc_q + 1'b1);
			if (cmd.mrg) cs_q <= '0;
			else if (cmd.cost_step) cs_q <= cs_q + 3'd1;
			if (cmd.r_init) p_q <= QB'(BUCKETS - 1);
			else if (cmd.l_init) p_q <= '0;
			else if (cmd.p_dec) p_q <= QB'(p_q - 1'b1);
			else if (cmd.p_inc) p_q <= QB'(p_q + 1'b1);
			if (cmd.l_init) best_q <= COST_MAX;
			else if (cmd.cmp && tot_s < best_q) best_q <= tot_s;
			if (cmd.emit) begin
				result_valid_q <= 1'b1;
				cnt_q <= '0;
				ovf_q <= 1'b0;
				vld_q <= '0;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			if (cnt_q == '0) begin
				clo_q <= item.centroid_low[CB-1:0];
				chi_q <= item.centroid_high[CB-1:0];
				axis_q <= (item.axis_sel == AXIS_BAD) ? AXIS_Z : item.axis_sel;
			end
		end
		if (cmd.prep) begin
			zero_q <= !(den > 0 && num > 0);
			top_q  <= (num >= den);
			r_q    <= R_W'($unsigned(num)) * R_W'(BUCKETS);
			dsh_q  <= R_W'($unsigned(den)) << (QB - 1);
			q_q    <= '0;
		end else if (cmd.div_step) begin
			if (r_q >= dsh_q) begin
				r_q <= r_q - dsh_q;
				q_q <= QB'({q_q, 1'b1});
			end else begin
				q_q <= QB'({q_q, 1'b0});
			end
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.r_init || cmd.l_init) begin
			acc_n_q <= '0;
		end else if (cmd.mrg && vld_q[p_q]) begin
			for (int a = 0; a < 3; a++) begin
				if (acc_n_q == '0 || $signed(ent_rd[a*CB +: CB]) < acc_lo_q[a])
					acc_lo_q[a] <= ent_rd[a*CB +: CB];
				if (acc_n_q == '0 || $signed(ent_rd[(3+a)*CB +: CB]) > acc_hi_q[a])
					acc_hi_q[a] <= ent_rd[(3+a)*CB +: CB];
			end
			acc_n_q <= CNT_W'(acc_n_q + ent_rd[ENT_W-1 -: CNT_W]);
		end
		if (cmd.cost_step) begin
			unique case (cs_q)
				3'd0: prod_q <= mul_p;
				3'd1: begin area_q <= AREA_W'(prod_q); prod_q <= mul_p; end
				3'd2: begin area_q <= area_q + AREA_W'(prod_q); prod_q <= mul_p; end
				3'd3: area_q <= area_q + AREA_W'(prod_q);
				3'd4: prod_q <= mul_p;
				3'd5: begin plo_q <= prod_q; prod_q <= mul_p; end
				3'd6: cost_q <= (acc_n_q == '0) ? '0 : cost_fit;
				default: ;
			endcase
		end
		if (cmd.cmp && (p_q == '0 || tot_s < best_q)) begin
			best_bkt_q  <= p_q;
			best_left_q <= acc_n_q;
		end
		if (cmd.emit) result_q <= res_d;
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	always_comb begin
		sts.ovf_now    = (cnt_q >= CNT_W'(MAX_PRIMS));
		sts.div_last   = (dc_q == DC_W'(QB - 1));
		sts.is_last    = item_q.last_item;
		sts.need_sweep = !degen && !few_prims;
		sts.cost_last  = (cs_q == 3'd6);
		sts.p_low_end  = (p_q == QB'(1));
		sts.p_high_end = (p_q == QB'(BUCKETS - 2));
		sts.out_free   = !result_valid_q || !result_stall;
	end

endmodule

@@ src/sah_binned_split_finder.sv @@
// Top level: binned surface-area split finder, controller plus datapath.
// Unless the count has overflowed, each request steps through prepare, a restoring divide
// that picks the bucket one bit per cycle, bucket read and bucket write; item_stall is held.
// A last request that needs a sweep then makes two passes over the partitions, right to left
// and left to right, through the single shared multiplier before the result shows.
// Reset clears the controller, counts and bucket valid bits at once; no clearing pass.
module sah_binned_split_finder import sbsf_pkg::*; #(
	parameter int BUCKETS    = BUCKETS_DEF,
	parameter int MAX_PRIMS  = MAX_PRIMS_DEF,
	parameter int COORD_BITS = COORD_DEF,
	parameter int SMALL_SET  = SMALL_SET_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  in_t  item,
	output logic result_valid,
	input  logic result_stall,
	output out_t result
);

	cmd_t cmd;
	sts_t sts;

	sbsf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	sbsf_dpath #(
		.BUCKETS    (BUCKETS),
		.MAX_PRIMS  (MAX_PRIMS),
		.COORD_BITS (COORD_BITS),
		.SMALL_SET  (SMALL_SET)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

@@ src/sbsf_checker.sv @@
// Port-level checker for the binned split finder, bound to the top level.
`include "sah_binned_split_finder_assert.svh"
module sbsf_checker import sbsf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input in_t  item,
	input logic result_valid,
	input logic result_stall,
	input out_t result
);

	`SBSF_ASSERT_NXT(a_res_hold, clk, arst_n, result_valid && result_stall, result_valid)
	`SBSF_ASSERT_NXT(a_res_stable, clk, arst_n, result_valid && result_stall, $stable(result))
	`SBSF_ASSERT_NXT(a_busy_after_req, clk, arst_n, item_valid && !item_stall, item_stall)
	`SBSF_ASSERT_NXT(a_no_early_res, clk, arst_n, item_valid && !item_stall && !item.last_item, !$rose(result_valid))

endmodule

bind sah_binned_split_finder sbsf_checker u_sbsf_checker (.*);
